FILE: rtl/falq_pkg.sv
// ----------------------------------------------------------------------------
// falq_pkg: shared types and constants of the Q-format 64-bit ALU
// Operation codes, the item carried down the pipeline and the divider state.
// ----------------------------------------------------------------------------
package falq_pkg;

  typedef enum logic [1:0] {
    MODE_ADD = 2'd0,
    MODE_SUB = 2'd1,
    MODE_MUL = 2'd2,
    MODE_DIV = 2'd3
  } mode_e;

  localparam int unsigned DataW = 64;
  localparam int unsigned DivSteps = 64;
  localparam logic [63:0] MaxPos = 64'h7FFF_FFFF_FFFF_FFFF;

  // side data that rides along with the divide chain
  typedef struct packed {
    mode_e       mode;
    logic [63:0] res;     // add/sub/mul result
    logic        gt;
    logic        lt;
    logic        eq;
    logic        dz;      // shifted divisor is zero
    logic        neg;     // quotient sign
  } item_t;

  // restoring divider state
  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] quo;     // dividend bits out, quotient bits in
    logic [63:0] den;
  } div_t;

endpackage

FILE: rtl/falq_if.sv
// ----------------------------------------------------------------------------
// falq_if: operand and result channels
// Valid/ready channels; a transfer happens when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface falq_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic signed [63:0] operand_a;
  logic signed [63:0] operand_b;

  modport source (output valid, mode, operand_a, operand_b, input ready);
  modport sink   (input valid, mode, operand_a, operand_b, output ready);
endinterface

interface falq_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] result;
  logic               a_greater;
  logic               a_less;
  logic               a_equal;

  modport source (output valid, result, a_greater, a_less, a_equal, input ready);
  modport sink   (input valid, result, a_greater, a_less, a_equal, output ready);
endinterface

FILE: rtl/falq_front.sv
// ----------------------------------------------------------------------------
// falq_front: four front stages
// Compare flags, partial products, divide normalization and operand scaling.
// ----------------------------------------------------------------------------
module falq_front #(
  parameter int unsigned FRAC_BITS = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  logic [1:0]       mode_i,
  input  logic [63:0]      a_i,
  input  logic [63:0]      b_i,
  output logic             vld_o,
  output falq_pkg::item_t  item_o,
  output falq_pkg::div_t   div_o
);
  import falq_pkg::*;

  localparam int unsigned Ex = (FRAC_BITS > 32) ? FRAC_BITS - 32 : 0;
  localparam int unsigned FfShift = FRAC_BITS - 2 * Ex;
  localparam logic [63:0] FracMask = (64'd1 << FRAC_BITS) - 64'd1;
  localparam logic [5:0] FracW = 6'(FRAC_BITS);

  function automatic logic [3:0] lz8(logic [7:0] v);
    logic [3:0] n;
    logic       done;
    n = 4'd0;
    done = 1'b0;
    for (int i = 7; i >= 0; i--) begin
      if (!done) begin
        if (v[i]) done = 1'b1;
        else n = n + 4'd1;
      end
    end
    return n;
  endfunction

  // ---------------- stage 1 ----------------
  logic [63:0] ia, ib, fa, fb, fas, fbs, xs, lzv;
  logic [3:0]  lzb[8];

  assign ia  = 64'($signed(a_i) >>> FRAC_BITS);
  assign ib  = 64'($signed(b_i) >>> FRAC_BITS);
  assign fa  = a_i & FracMask;
  assign fb  = b_i & FracMask;
  assign fas = fa >> Ex;
  assign fbs = fb >> Ex;
  assign xs  = a_i ^ {64{a_i[63]}};
  assign lzv = {xs[62:1], 2'b11};

  always_comb begin
    for (int j = 0; j < 8; j++) lzb[j] = lz8(lzv[8*j +: 8]);
  end

  logic        vld1_q;
  logic [1:0]  mode1_q;
  logic [63:0] a1_q, b1_q;
  logic        gt1_q, lt1_q, eq1_q;
  logic [3:0]  lzb1_q[8];
  logic [63:0] pa0_q, pb0_q, ff_q;
  logic [31:0] pa1_q, pa2_q, pb1_q, pb2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mode1_q <= mode_i;
      a1_q    <= a_i;
      b1_q    <= b_i;
      gt1_q   <= $signed(a_i) > $signed(b_i);
      lt1_q   <= $signed(a_i) < $signed(b_i);
      eq1_q   <= a_i == b_i;
      lzb1_q  <= lzb;
      // low 64 bits of ia*b and fa*ib as 32x32 pieces
      pa0_q   <= ia[31:0] * b_i[31:0];
      pa1_q   <= ia[63:32] * b_i[31:0];
      pa2_q   <= ia[31:0] * b_i[63:32];
      pb0_q   <= fa[31:0] * ib[31:0];
      pb1_q   <= fa[63:32] * ib[31:0];
      pb2_q   <= fa[31:0] * ib[63:32];
      ff_q    <= fas[31:0] * fbs[31:0];
    end
  end

  // ---------------- stage 2 ----------------
  logic [6:0] lsum;
  logic       ldone;
  logic [5:0] sl;

  always_comb begin
    lsum  = 7'd0;
    ldone = 1'b0;
    for (int j = 7; j >= 0; j--) begin
      if (!ldone) begin
        lsum = lsum + 7'(lzb1_q[j]);
        if (lzb1_q[j] != 4'd8) ldone = 1'b1;
      end
    end
    sl = (lsum > 7'(FRAC_BITS)) ? FracW : lsum[5:0];
  end

  logic        vld2_q;
  logic [1:0]  mode2_q;
  logic [63:0] a2_q, b2_q, m1_q, m2_q, ffs_q;
  logic        gt2_q, lt2_q, eq2_q;
  logic [5:0]  sl2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld2_q <= 1'b0;
    end else if (en_i) begin
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mode2_q <= mode1_q;
      a2_q    <= a1_q;
      b2_q    <= b1_q;
      gt2_q   <= gt1_q;
      lt2_q   <= lt1_q;
      eq2_q   <= eq1_q;
      sl2_q   <= sl;
      m1_q    <= pa0_q + {pa1_q + pa2_q, 32'd0};
      m2_q    <= pb0_q + {pb1_q + pb2_q, 32'd0};
      ffs_q   <= ff_q >> FfShift;
    end
  end

  // ---------------- stage 3 ----------------
  logic [63:0] res3;

  always_comb begin
    case (mode_e'(mode2_q))
      MODE_ADD: res3 = a2_q + b2_q;
      MODE_SUB: res3 = a2_q - b2_q;
      MODE_MUL: res3 = m1_q + m2_q + ffs_q;
      default:  res3 = '0;
    endcase
  end

  logic        vld3_q;
  logic [1:0]  mode3_q;
  logic [63:0] res3_q, num3_q, den3_q;
  logic        gt3_q, lt3_q, eq3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld3_q <= 1'b0;
    end else if (en_i) begin
      vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mode3_q <= mode2_q;
      gt3_q   <= gt2_q;
      lt3_q   <= lt2_q;
      eq3_q   <= eq2_q;
      res3_q  <= res3;
      num3_q  <= a2_q << sl2_q;
      den3_q  <= 64'($signed(b2_q) >>> (FracW - sl2_q));
    end
  end

  // ---------------- stage 4 ----------------
  logic             vld4_q;
  item_t            item4_q;
  div_t             div4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld4_q <= 1'b0;
    end else if (en_i) begin
      vld4_q <= vld3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item4_q.mode <= mode_e'(mode3_q);
      item4_q.res  <= res3_q;
      item4_q.gt   <= gt3_q;
      item4_q.lt   <= lt3_q;
      item4_q.eq   <= eq3_q;
      item4_q.dz   <= den3_q == 64'd0;
      item4_q.neg  <= num3_q[63] ^ den3_q[63];
      div4_q.rem   <= '0;
      div4_q.quo   <= num3_q[63] ? (64'd0 - num3_q) : num3_q;
      div4_q.den   <= den3_q[63] ? (64'd0 - den3_q) : den3_q;
    end
  end

  assign vld_o  = vld4_q;
  assign item_o = item4_q;
  assign div_o  = div4_q;

endmodule

FILE: rtl/falq_div_stage.sv
// ----------------------------------------------------------------------------
// falq_div_stage: one restoring divide step
// Shifts one dividend bit into the remainder and develops one quotient bit.
// ----------------------------------------------------------------------------
module falq_div_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  falq_pkg::item_t  item_i,
  input  falq_pkg::div_t   div_i,
  output logic             vld_o,
  output falq_pkg::item_t  item_o,
  output falq_pkg::div_t   div_o
);
  import falq_pkg::*;

  logic [63:0] part;
  logic        fits;
  div_t        div_d, div_q;
  item_t       item_q;
  logic        vld_q;

  // remainder stays below the divisor (at most 2^63), so part never overflows
  assign part = {div_i.rem[62:0], div_i.quo[63]};
  assign fits = part >= div_i.den;

  always_comb begin
    div_d.den = div_i.den;
    div_d.rem = fits ? (part - div_i.den) : part;
    div_d.quo = {div_i.quo[62:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q  <= div_d;
      item_q <= item_i;
    end
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;
  assign div_o  = div_q;

endmodule

FILE: rtl/fixed_point_alu_q64.sv
// ----------------------------------------------------------------------------
// fixed_point_alu_q64: pipelined 64-bit signed Q-format ALU
// Add, subtract, multiply and divide with compare flags on every result.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  carries mode (0 add, 1 sub, 2 mul, 3 div) and two signed 64-bit
//         operands with FRAC_BITS fraction bits; out_o carries the result
//         and the a_greater / a_less / a_equal flags. One result per transfer,
//         in order.
//   Pipeline: every operation passes through 4 front stages, 64 divide
//         steps and 1 output register between input transfer and out_o.
//         All modes share one pipe so order is kept.
//   Throughput: one transfer per cycle while out_o is not stalled. The 64-step restoring divider is
//         fully unrolled, one quotient bit per stage.
//   Stall: while a result waits on out_o with ready low, the whole pipe
//         freezes and in_i.ready drops; nothing is dropped or repeated.
//         Empty slots still advance while the output register is free.
//   Reset: rst_ni clears all valid bits; the pipe comes up empty and ready.
//   Divide by a shifted divisor of zero returns the largest positive value.
// ----------------------------------------------------------------------------
module fixed_point_alu_q64 #(
  parameter int unsigned FRAC_BITS = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  falq_in_if.sink  in_i,
  falq_out_if.source out_o
);
  import falq_pkg::*;

  // global advance: move when the output slot is empty or being taken
  logic en;
  assign en = !out_o.valid || out_o.ready;
  assign in_i.ready = en;

  logic  vld_c [DivSteps+1];
  item_t item_c[DivSteps+1];
  div_t  div_c [DivSteps+1];

  falq_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .vld_i (in_i.valid),
    .mode_i(in_i.mode),
    .a_i   (in_i.operand_a),
    .b_i   (in_i.operand_b),
    .vld_o (vld_c[0]),
    .item_o(item_c[0]),
    .div_o (div_c[0])
  );

  // unrolled divider, one quotient bit per stage
  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    falq_div_stage u_step (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .vld_i (vld_c[k]),
      .item_i(item_c[k]),
      .div_i (div_c[k]),
      .vld_o (vld_c[k+1]),
      .item_o(item_c[k+1]),
      .div_o (div_c[k+1])
    );
  end

  // final select: divide result with sign and zero-divisor fixup
  item_t       last;
  logic [63:0] quo;
  logic [63:0] res_d, res_q;
  logic        vld_q, gt_q, lt_q, eq_q;

  assign last = item_c[DivSteps];
  assign quo  = div_c[DivSteps].quo;

  always_comb begin
    if (last.mode == MODE_DIV) begin
      if (last.dz)       res_d = MaxPos;
      else if (last.neg) res_d = 64'd0 - quo;
      else               res_d = quo;
    end else begin
      res_d = last.res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en) begin
      vld_q <= vld_c[DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
      gt_q  <= last.gt;
      lt_q  <= last.lt;
      eq_q  <= last.eq;
    end
  end

  assign out_o.valid     = vld_q;
  assign out_o.result    = res_q;
  assign out_o.a_greater = gt_q;
  assign out_o.a_less    = lt_q;
  assign out_o.a_equal   = eq_q;

`ifndef SYNTHESIS
  // exactly one compare relation holds for a real result
  a_flags_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> $onehot({out_o.a_greater, out_o.a_less, out_o.a_equal}))
    else $error("compare flags not exclusive");

  // a drained output slot never blocks the input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_o.valid |-> in_i.ready)
    else $error("input blocked with empty output");

  // a stalled result is frozen together with its a_equal flag
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=> (out_o.valid && $stable(out_o.result)
      && $stable(out_o.a_equal)))
    else $error("pipe moved during stall");
`endif

endmodule

FILE: bench/falq_tb_pkg.sv
// ----------------------------------------------------------------------------
// falq_tb_pkg: bench-side types for the Q-format ALU checker
// The expected-result record.
// ----------------------------------------------------------------------------
package falq_tb_pkg;
  import falq_pkg::*;

  typedef struct packed {
    logic [63:0] value;
    logic        gt;
    logic        lt;
    logic        eq;
  } alu_result_t;
endpackage

FILE: bench/falq_checker.sv
// ----------------------------------------------------------------------------
// falq_checker: result predictor and scoreboard for the Q-format ALU
// Watches both channels, computes each result from the operands and compares.
// ----------------------------------------------------------------------------
module falq_checker #(
  parameter int unsigned FRAC_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  falq_in_if         in_mon,
  falq_out_if        out_mon,
  output int         fail_count_o,
  output int         pending_o
);
  import falq_pkg::*;
  import falq_tb_pkg::*;

  alu_result_t expected_q[$];

  function automatic logic [63:0] shr_arith(logic [63:0] x, int unsigned s);
    return $unsigned($signed(x) >>> s);
  endfunction

  function automatic logic [63:0] q_mul(logic [63:0] a, logic [63:0] b);
    int unsigned ex;
    logic [63:0] ia, ib, fa, fb, fmask, ff, acc;
    ex = (FRAC_BITS > 32) ? FRAC_BITS - 32 : 0;
    fmask = (64'd1 << FRAC_BITS) - 64'd1;
    ia = shr_arith(a, FRAC_BITS);
    ib = shr_arith(b, FRAC_BITS);
    fa = a & fmask;
    fb = b & fmask;
    ff = (fa >> ex) * (fb >> ex);
    acc = (ia * ib) << FRAC_BITS;
    acc = acc + ia * fb + fa * ib + (ff >> (FRAC_BITS - 2 * ex));
    return acc;
  endfunction

  function automatic logic [63:0] q_div(logic [63:0] a, logic [63:0] b);
    int unsigned sl;
    logic [63:0] num, den, mn, md, quo;
    logic neg;
    sl = 0;
    // count sign copies below bit 63, bit 0 never counts
    for (int i = 62; i > 0; i--) begin
      if (a[i] != a[63]) break;
      sl++;
    end
    if (sl > FRAC_BITS) sl = FRAC_BITS;
    num = a << sl;
    den = shr_arith(b, FRAC_BITS - sl);
    if (den == 64'd0) return MaxPos;
    neg = num[63] ^ den[63];
    mn = num[63] ? -num : num;
    md = den[63] ? -den : den;
    quo = mn / md;
    return neg ? -quo : quo;
  endfunction

  function automatic alu_result_t alu_predict(mode_e mode, logic [63:0] a, logic [63:0] b);
    alu_result_t r;
    case (mode)
      MODE_ADD: r.value = a + b;
      MODE_SUB: r.value = a - b;
      MODE_MUL: r.value = q_mul(a, b);
      default:  r.value = q_div(a, b);
    endcase
    r.gt = $signed(a) > $signed(b);
    r.lt = $signed(a) < $signed(b);
    r.eq = a == b;
    return r;
  endfunction

  assign pending_o = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    alu_result_t exp_r;
    if (!rst_ni) begin
      fail_count_o <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready)
        expected_q.push_back(alu_predict(mode_e'(in_mon.mode), in_mon.operand_a,
                                         in_mon.operand_b));
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          $error("result transfer with nothing expected");
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (out_mon.result !== exp_r.value || out_mon.a_greater !== exp_r.gt ||
              out_mon.a_less !== exp_r.lt || out_mon.a_equal !== exp_r.eq)
            fail_count_o <= fail_count_o + 1;
          if (out_mon.result !== exp_r.value)
            $error("result: expected %h, got %h", exp_r.value, out_mon.result);
          if (out_mon.a_greater !== exp_r.gt)
            $error("a_greater: expected %b, got %b", exp_r.gt, out_mon.a_greater);
          if (out_mon.a_less !== exp_r.lt)
            $error("a_less: expected %b, got %b", exp_r.lt, out_mon.a_less);
          if (out_mon.a_equal !== exp_r.eq)
            $error("a_equal: expected %b, got %b", exp_r.eq, out_mon.a_equal);
        end
      end
    end
  end
endmodule

FILE: bench/tb_fixed_point_alu_q64.sv
// ----------------------------------------------------------------------------
// tb_fixed_point_alu_q64: testbench top for the Q-format 64-bit ALU
// Drives directed corner operands then random ones under varying idle rates
// and a long output stall; the checker predicts and scores every result.
// ----------------------------------------------------------------------------
module tb_fixed_point_alu_q64;
  import falq_pkg::*;

  localparam int unsigned FRAC_BITS = 32;
  localparam int          RandItems = 1200;
  // pipe depth from the block's header, plus margin
  localparam int          DrainCycles = 100;
  localparam longint      CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  falq_in_if  in_ch();
  falq_out_if out_ch();

  int fail_count;
  int pending;
  longint cycle_count = 0;

  // idle rates in percent; sender and receiver swap roles over the run
  int src_idle_pct = 32;
  int snk_idle_pct = 60;
  // long hold-off on the result side to back the pipe up
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int hold_cycles = 0;

  fixed_point_alu_q64 #(.FRAC_BITS(FRAC_BITS)) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  falq_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // watchdog: a stuck handshake ends the run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // result side: random backpressure, or a counted hold-off when requested
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      out_ch.ready <= 1'b0;
      hold_cycles  <= 300;
      hold_done    <= 1'b1;
    end else if (hold_cycles > 0) begin
      out_ch.ready <= 1'b0;
      hold_cycles  <= hold_cycles - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // operand with interesting bit patterns: extremes, near-zero, random
  function automatic logic [63:0] pick_operand();
    logic [63:0] v;
    case ($urandom_range(9))
      0: v = 64'h7FFF_FFFF_FFFF_FFFF;
      1: v = 64'h8000_0000_0000_0000;
      2: v = 64'(signed'($urandom_range(8)) - 4);
      3: v = {{32{$urandom_range(1) == 1}}, 32'($urandom)};      // small magnitude
      4: v = $signed({$urandom, $urandom}) >>> $urandom_range(63);
      5: v = 64'(signed'($urandom_range(200)) - 100) << FRAC_BITS;  // integers
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  // offer one transfer, holding it until accepted
  task automatic send_op(mode_e mode, logic [63:0] a, logic [63:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.mode      <= mode;
    in_ch.operand_a <= a;
    in_ch.operand_b <= b;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic send_random(int count);
    for (int i = 0; i < count; i++)
      send_op(mode_e'($urandom_range(3)), pick_operand(), pick_operand());
    in_ch.valid <= 1'b0;
  endtask

  localparam logic [63:0] MaxV = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MinV = 64'h8000_0000_0000_0000;
  localparam logic [63:0] One  = 64'd1 << FRAC_BITS;

  initial begin
    in_ch.valid     <= 1'b0;
    in_ch.mode      <= MODE_ADD;
    in_ch.operand_a <= '0;
    in_ch.operand_b <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corners: wraparound, equal operands, divide by zero,
    // divisor shifted to zero, min / -1, fraction-only products
    send_op(MODE_ADD, MaxV, 64'd1);
    send_op(MODE_ADD, MinV, MinV);
    send_op(MODE_SUB, MinV, 64'd1);
    send_op(MODE_SUB, MaxV, MaxV);
    send_op(MODE_SUB, 64'd0, MinV);
    send_op(MODE_MUL, MaxV, MaxV);
    send_op(MODE_MUL, MinV, MinV);
    send_op(MODE_MUL, MinV, MaxV);
    send_op(MODE_MUL, 64'h0000_0000_FFFF_FFFF, 64'h0000_0000_FFFF_FFFF);
    send_op(MODE_MUL, -One, One + (One >> 1));
    send_op(MODE_MUL, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_op(MODE_DIV, One, 64'd0);
    send_op(MODE_DIV, -One, 64'd0);
    send_op(MODE_DIV, One, 64'd1);
    send_op(MODE_DIV, MinV, -One);
    send_op(MODE_DIV, MinV, 64'hFFFF_FFFF_FFFF_FFFF);
    send_op(MODE_DIV, MaxV, MinV);
    send_op(MODE_DIV, 64'd0, One);
    send_op(MODE_DIV, 64'd1, One);
    send_op(MODE_DIV, 64'hFFFF_FFFF_FFFF_FFFF, MaxV);
    send_op(MODE_DIV, 64'd7 * One, -(64'd2 * One));
    send_op(MODE_ADD, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
    send_op(MODE_SUB, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    in_ch.valid <= 1'b0;

    // slow sender, slow receiver
    send_random(RandItems / 3);
    // receiver stalls long while the sender keeps offering
    src_idle_pct = 0;
    hold_req = 1'b1;
    send_random(150);
    // swap the idle rates
    src_idle_pct = 60;
    snk_idle_pct = 32;
    send_random(RandItems / 3);
    // full rate both ways
    src_idle_pct = 0;
    snk_idle_pct = 0;
    send_random(RandItems / 3);

    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end
endmodule

FILE: filelist.f
rtl/falq_pkg.sv
rtl/falq_if.sv
rtl/falq_front.sv
rtl/falq_div_stage.sv
rtl/fixed_point_alu_q64.sv
bench/falq_tb_pkg.sv
bench/falq_checker.sv
bench/tb_fixed_point_alu_q64.sv
